[rtl/imu_szoc_pkg.sv]
// ----------------------------------------------------------------------------
// IMU still zero offset calibrator package
// Shared widths, codes and stage payload types for the calibrator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package imu_szoc_pkg;

  // Six axes per item: accel X, Y, Z, then gyro X, Y, Z.
  localparam int AXES      = 6;
  localparam int ACC_AXES  = 3;
  localparam int AXIS_Z    = 2;
  localparam int SMP_W     = 16;

  // Calibration run length and the widths that follow from it.
  localparam int STILL_RUN_LEN = 100;
  localparam int RUN_W   = $clog2(STILL_RUN_LEN + 1);
  localparam int PROG_W  = 7;
  localparam int SUM_W   = SMP_W + $clog2(STILL_RUN_LEN);
  localparam int MAG_W   = SUM_W - 1;

  // Reciprocal for dividing a sum magnitude by the run length.
  // The error term times the largest magnitude stays below 2**DIV_SHIFT,
  // so the truncated product equals the exact quotient.
  localparam int DIV_SHIFT = 29;
  localparam int MULT_W    = 23;
  localparam logic [MULT_W-1:0] DIV_MULT =
    MULT_W'((2**DIV_SHIFT + STILL_RUN_LEN - 1) / STILL_RUN_LEN);
  localparam int PROD_W    = MAG_W + MULT_W;

  localparam logic [SMP_W-1:0] ONE_G           = 16'd16384;
  localparam logic [SMP_W-1:0] THRESHOLD_RESET = 16'd400;

  // Calibration phases.
  localparam int PHASE_W = 2;
  localparam logic [PHASE_W-1:0] PH_BASE  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_ACCUM = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DONE  = 2'd2;

  // Result kinds.
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_CAL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OFFS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CORR = 2'd2;

  typedef logic [AXES-1:0][SMP_W-1:0] axes_t;
  typedef logic [AXES-1:0][SUM_W-1:0] sums_t;

  // Item held in the input register.
  typedef struct packed {
    logic  restart;
    axes_t smp;
  } in_item_t;

  // Item passed from the tracking stage to the output stage.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PROG_W-1:0] progress;
    axes_t             smp;
    sums_t             sum;
  } mid_t;

endpackage

`default_nettype wire

[rtl/imu_szoc_track.sv]
// ----------------------------------------------------------------------------
// IMU calibrator tracking stage
// Runs the stillness check, run counter and axis sums, and registers the
// decision for each item into the middle pipeline register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imu_szoc_track (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [15:0]           cfg_wr_data,
  input  wire logic                  load,
  input  wire logic                  drain,
  input  wire imu_szoc_pkg::in_item_t item,
  output logic                       mid_valid,
  output imu_szoc_pkg::mid_t         mid
);

  import imu_szoc_pkg::*;

  logic [SMP_W-1:0]                threshold;
  logic [PHASE_W-1:0]              phase, phase_next;
  logic [ACC_AXES-1:0][SMP_W-1:0]  prev, prev_next;
  logic [RUN_W-1:0]                run, run_next, run_inc;
  sums_t                           sums, sums_next, sums_add;
  mid_t                            mid_next;
  logic                            still;
  logic signed [SMP_W:0]           diff [ACC_AXES];
  logic [SMP_W:0]                  diff_mag [ACC_AXES];

  // Motion threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  // Per-axis change since the previous sample, taken at 17 bits.
  always_comb begin
    still = 1'b1;
    for (int i = 0; i < ACC_AXES; i++) begin
      diff[i] = $signed({item.smp[i][SMP_W-1], item.smp[i]})
              - $signed({prev[i][SMP_W-1], prev[i]});
      diff_mag[i] = diff[i][SMP_W] ? (SMP_W+1)'(-diff[i]) : diff[i];
      if (diff_mag[i] > {1'b0, threshold}) begin
        still = 1'b0;
      end
    end
  end

  // Running sums with this sample added.
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      sums_add[i] = sums[i] + {{(SUM_W-SMP_W){item.smp[i][SMP_W-1]}}, item.smp[i]};
    end
  end

  assign run_inc = run + RUN_W'(1);

  // Phase sequencing and the result decision.
  always_comb begin
    phase_next        = phase;
    prev_next         = prev;
    run_next          = run;
    sums_next         = sums;
    mid_next.kind     = KIND_CAL;
    mid_next.progress = '0;
    mid_next.smp      = item.smp;
    mid_next.sum      = sums_add;
    if (item.restart) begin
      phase_next = PH_BASE;
      run_next   = '0;
      sums_next  = '0;
    end else begin
      unique case (phase)
        PH_BASE: begin
          for (int i = 0; i < ACC_AXES; i++) prev_next[i] = item.smp[i];
          run_next   = '0;
          phase_next = PH_ACCUM;
        end
        PH_ACCUM: begin
          for (int i = 0; i < ACC_AXES; i++) prev_next[i] = item.smp[i];
          if (!still) begin
            run_next  = '0;
            sums_next = '0;
          end else begin
            run_next          = run_inc;
            sums_next         = sums_add;
            mid_next.progress = PROG_W'(run_inc);
            if (run_inc >= RUN_W'(STILL_RUN_LEN)) begin
              mid_next.kind = KIND_OFFS;
              phase_next    = PH_DONE;
            end
          end
        end
        default: begin
          // Calibrated: the run stays at its final count.
          mid_next.kind     = KIND_CORR;
          mid_next.progress = PROG_W'(run);
        end
      endcase
    end
  end

  // Calibration state, updated as an item moves into the middle register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_BASE;
      prev  <= '0;
      run   <= '0;
      sums  <= '0;
    end else if (load) begin
      phase <= phase_next;
      prev  <= prev_next;
      run   <= run_next;
      sums  <= sums_next;
    end
  end

  // Middle pipeline register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (load) begin
      mid_valid <= 1'b1;
    end else if (drain) begin
      mid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mid <= mid_next;
    end
  end

endmodule

`default_nettype wire

[rtl/imu_szoc_output.sv]
// ----------------------------------------------------------------------------
// IMU calibrator output stage
// Divides the final sums into offsets, applies offsets to calibrated
// samples and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imu_szoc_output (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     drain,
  input  wire imu_szoc_pkg::mid_t       mid,
  input  wire logic                     out_ready,
  output logic                          out_valid,
  output logic [imu_szoc_pkg::KIND_W-1:0] out_kind,
  output logic [imu_szoc_pkg::PROG_W-1:0] out_progress,
  output imu_szoc_pkg::axes_t           out_vals
);

  import imu_szoc_pkg::*;

  axes_t offsets;
  axes_t quot;
  axes_t corr;
  axes_t vals_next;

  // Signed sum divided by the run length, truncated toward zero.
  function automatic logic [SMP_W:0] div_run(input logic [SUM_W-1:0] sum);
    logic              neg;
    logic [SUM_W-1:0]  mag_full;
    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [SMP_W-1:0]  q_mag;
    neg      = sum[SUM_W-1];
    mag_full = neg ? (~sum + SUM_W'(1)) : sum;
    mag      = mag_full[MAG_W-1:0];
    prod     = PROD_W'(mag) * PROD_W'(DIV_MULT);
    q_mag    = prod[DIV_SHIFT +: SMP_W];
    return neg ? ((SMP_W+1)'(0) - {1'b0, q_mag}) : {1'b0, q_mag};
  endfunction

  // Offsets from the final sums; Z accel also loses one g.
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      logic [SMP_W:0] q;
      q = div_run(mid.sum[i]);
      if (i == AXIS_Z) begin
        q = q - {1'b0, ONE_G};
      end
      quot[i] = q[SMP_W-1:0];
    end
  end

  // Corrected sample, wrapping to 16 bits.
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      corr[i] = mid.smp[i] - offsets[i];
    end
  end

  // Value fields by result kind.
  always_comb begin
    case (mid.kind)
      KIND_OFFS: vals_next = quot;
      KIND_CORR: vals_next = corr;
      default:   vals_next = '0;
    endcase
  end

  // Stored offsets, written by the completing item.
  always_ff @(posedge clk) begin
    if (rst) begin
      offsets <= '0;
    end else if (drain && mid.kind == KIND_OFFS) begin
      offsets <= quot;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (drain) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_kind     <= mid.kind;
      out_progress <= mid.progress;
      out_vals     <= vals_next;
    end
  end

endmodule

`default_nettype wire

[rtl/imu_still_zero_offset_calibrator.sv]
// ----------------------------------------------------------------------------
// IMU still zero offset calibrator
// Finds accelerometer and gyro zero offsets over a run of still samples,
// then returns every later sample with its offsets removed.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                         Contents
//  s_*       in         s_tvalid s_tready s_tdata s_tuser  raw six-axis item
//  m_*       out        m_tvalid m_tready m_tdata m_tuser  offsets or corrected item
//  cfg_*     in         cfg_wr_en cfg_wr_data             motion threshold
//
//  One item per cycle sustained while m_tready is not held low; each result is offered
//  once its item has moved through the input register, tracking register and result register.
//  The offset divide is a reciprocal multiply per axis in the output stage.
//  Reset is synchronous and clears the calibration state; threshold is 400.
//  A stalled output fills the pipeline registers before s_tready drops.
//
`timescale 1ns / 1ps
`default_nettype none

module imu_still_zero_offset_calibrator (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wr_en,
  input  wire logic [15:0]  cfg_wr_data,  // motion_threshold
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [95:0]  s_tdata,      // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  input  wire logic         s_tuser,      // func
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [103:0]      m_tdata,      // progress, val_ax, val_ay, val_az, val_gx,
                                          // val_gy, val_gz, zero pad
  output logic [1:0]        m_tuser       // out_kind
);

  import imu_szoc_pkg::*;

  logic      in_valid;
  in_item_t  in_item;
  logic      mid_valid;
  mid_t      mid;
  logic      load, drain;
  logic [KIND_W-1:0] out_kind;
  logic [PROG_W-1:0] out_progress;
  axes_t     out_vals;

  // Stage advance: each register moves when the one after it has room.
  assign drain    = mid_valid && (!m_tvalid || m_tready);
  assign load     = in_valid && (!mid_valid || drain);
  assign s_tready = !in_valid || load;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.restart <= s_tuser;
      in_item.smp     <= s_tdata;
    end
  end

  imu_szoc_track u_track (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .load        (load),
    .drain       (drain),
    .item        (in_item),
    .mid_valid   (mid_valid),
    .mid         (mid)
  );

  imu_szoc_output u_output (
    .clk          (clk),
    .rst          (rst),
    .drain        (drain),
    .mid          (mid),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_kind     (out_kind),
    .out_progress (out_progress),
    .out_vals     (out_vals)
  );

  // Result packing.
  assign m_tdata = {1'b0, out_vals, out_progress};
  assign m_tuser = out_kind;

endmodule

`default_nettype wire

[bench/imu_still_zero_offset_calibrator_tb.sv]
// ----------------------------------------------------------------------------
// IMU still zero offset calibrator testbench
// Drives restart and sample items through the calibrator, keeps its own
// model of the calibration state, and checks every result field by field.
// Covers the baseline, still and moving samples, threshold edges, offset
// wrap, corrected output, back pressure and random calibration sessions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imu_still_zero_offset_calibrator_tb;
  import imu_szoc_pkg::*;

  localparam int RANDOM_ITEMS = 430;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int PIPE_SETTLE  = 8;

  // Expected result: kind, run count and six value fields.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PROG_W-1:0] progress;
    axes_t             vals;
  } calib_result_t;

  // Receiver stall patterns.
  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_pattern_e;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_wr_en = 1'b0;
  logic [15:0]  cfg_wr_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;     // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  logic         s_tuser = 1'b0;   // func
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;          // progress, val_ax, val_ay, val_az, val_gx, val_gy,
                                  // val_gz, zero pad
  logic [1:0]   m_tuser;          // out_kind

  // Calibration state as the checker sees it.
  logic [15:0]        motion_limit;
  logic [PHASE_W-1:0] cal_phase;
  int                 prev_acc [ACC_AXES];
  int                 still_count;
  int                 axis_sum [AXES];
  logic [SMP_W-1:0]   axis_offset [AXES];
  calib_result_t      pending_results [$];

  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int offset_sets = 0;
  int threshold_writes = 0;
  int cycle_count = 0;

  // Sender burst control and receiver hold-off request.
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int hold_request = 0;

  string val_names [AXES] = '{"val_ax", "val_ay", "val_az", "val_gx", "val_gy", "val_gz"};

  imu_still_zero_offset_calibrator dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  always #5 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: switches between stall patterns, and honors a long hold-off
  // that it counts down itself.
  rx_pattern_e ready_mode = RX_ALWAYS;
  int mode_left = 0;
  int hold_left = 0;
  int ready_tick = 0;

  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (mode_left == 0) begin
      ready_mode = rx_pattern_e'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    ready_tick++;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (ready_mode)
        RX_ALWAYS: m_tready <= 1'b1;
        RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE: m_tready <= ($urandom_range(0, 9) < 3);
        default:   m_tready <= ((ready_tick % 5) >= 2);
      endcase
    end
  end

  task automatic report_mismatch(input string field, input logic [103:0] want,
                                 input logic [103:0] got);
    $display("MISMATCH %s on result %0d: expected 0x%0h, got 0x%0h",
             field, results_checked, want, got);
    mismatches++;
  endtask

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    calib_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, m_tdata);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (m_tuser !== want.kind)
          report_mismatch("out_kind", 104'(want.kind), 104'(m_tuser));
        if (m_tdata[PROG_W-1:0] !== want.progress)
          report_mismatch("progress", 104'(want.progress), 104'(m_tdata[PROG_W-1:0]));
        for (int i = 0; i < AXES; i++) begin
          if (m_tdata[PROG_W + SMP_W*i +: SMP_W] !== want.vals[i])
            report_mismatch(val_names[i], 104'(want.vals[i]),
                            104'(m_tdata[PROG_W + SMP_W*i +: SMP_W]));
        end
      end
    end
  end

  // Advance the calibration state by one accepted item and return the
  // result that it must produce.
  function automatic calib_result_t advance_calibration(input logic func, input axes_t smp);
    calib_result_t r;
    int s [AXES];
    int d;
    bit still;
    int q;
    r = '0;
    r.kind = KIND_CAL;
    for (int i = 0; i < AXES; i++) begin
      s[i] = int'($signed(smp[i]));
    end
    // A restart drops the run and the sums; offsets survive but stay hidden.
    if (func) begin
      cal_phase = PH_BASE;
      still_count = 0;
      for (int i = 0; i < AXES; i++) axis_sum[i] = 0;
      return r;
    end
    case (cal_phase)
      PH_BASE: begin
        for (int i = 0; i < ACC_AXES; i++) prev_acc[i] = s[i];
        still_count = 0;
        cal_phase = PH_ACCUM;
      end
      PH_ACCUM: begin
        still = 1'b1;
        for (int i = 0; i < ACC_AXES; i++) begin
          d = s[i] - prev_acc[i];
          if (d < 0) d = -d;
          if (d > int'(motion_limit)) still = 1'b0;
          prev_acc[i] = s[i];
        end
        if (!still) begin
          still_count = 0;
          for (int i = 0; i < AXES; i++) axis_sum[i] = 0;
        end else begin
          still_count++;
          for (int i = 0; i < AXES; i++) axis_sum[i] += s[i];
          // The run is complete: the offsets are the truncated means.
          if (still_count >= STILL_RUN_LEN) begin
            for (int i = 0; i < AXES; i++) begin
              q = axis_sum[i] / STILL_RUN_LEN;
              if (i == AXIS_Z) q = q - int'(ONE_G);
              axis_offset[i] = q[SMP_W-1:0];
              r.vals[i] = axis_offset[i];
            end
            cal_phase = PH_DONE;
            r.kind = KIND_OFFS;
            offset_sets++;
          end
        end
      end
      default: begin
        for (int i = 0; i < AXES; i++) r.vals[i] = smp[i] - axis_offset[i];
        r.kind = KIND_CORR;
      end
    endcase
    r.progress = (still_count > 127) ? 7'd127 : PROG_W'(still_count);
    return r;
  endfunction

  // Offer one item in the sender's burst pattern and record its result.
  task automatic send_item(input logic func, input axes_t smp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= smp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(advance_calibration(func, smp));
    items_sent++;
  endtask

  // Stop offering, then wait for every outstanding result and the pipeline.
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [15:0] value);
    drain_results();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    motion_limit = value;
    threshold_writes++;
  endtask

  function automatic axes_t pack_axes(input int ax, input int ay, input int az,
                                      input int gx, input int gy, input int gz);
    axes_t r;
    r[0] = 16'(ax);
    r[1] = 16'(ay);
    r[2] = 16'(az);
    r[3] = 16'(gx);
    r[4] = 16'(gy);
    r[5] = 16'(gz);
    return r;
  endfunction

  function automatic axes_t random_axes();
    axes_t r;
    for (int i = 0; i < AXES; i++) r[i] = 16'($urandom);
    return r;
  endfunction

  // A reading within the threshold of the previous one, sometimes right on it.
  function automatic logic [15:0] near_value(input int prev);
    int amp;
    int r;
    int v;
    amp = (motion_limit > 16'd3000) ? 3000 : int'(motion_limit);
    if ($urandom_range(0, 9) == 0) begin
      v = ($urandom_range(0, 1) != 0) ? prev + int'(motion_limit) : prev - int'(motion_limit);
    end else begin
      r = $urandom_range(0, 2 * amp);
      v = prev + r - amp;
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  // A reading beyond the threshold where the range allows one.
  function automatic logic [15:0] far_value(input int prev);
    int edge_hi;
    int edge_lo;
    edge_hi = prev + int'(motion_limit) + 1;
    edge_lo = prev - int'(motion_limit) - 1;
    if (edge_hi <= 32767 && ($urandom_range(0, 1) != 0 || edge_lo < -32768))
      return 16'($urandom_range(edge_hi + 32768, 65535) - 32768);
    if (edge_lo >= -32768)
      return 16'($urandom_range(0, edge_lo + 32768) - 32768);
    return 16'($urandom);
  endfunction

  // Baseline, threshold edges and restarts at the reset threshold.
  task automatic test_directed_cases();
    send_item(1'b0, pack_axes(-32768, -32768, -32768, 32767, 32767, 32767));
    send_item(1'b0, pack_axes(32767, 32767, 32767, -32768, -32768, -32768));
    send_item(1'b0, pack_axes(32367, 32767, 32767, 0, 0, 0));
    send_item(1'b0, pack_axes(32367, 32366, 32767, 1, -1, 1));
    send_item(1'b0, pack_axes(32367, 32366, 32767, -1, 1, -1));
    send_item(1'b0, pack_axes(31967, 31966, 32367, 12345, -12345, 7));
    send_item(1'b1, '1);
    send_item(1'b0, '0);
    send_item(1'b1, {AXES{16'h5555}});
    send_item(1'b0, {AXES{16'hAAAA}});
    send_item(1'b0, {AXES{16'h5555}});
    send_item(1'b1, '0);
  endtask

  // Full calibrations at both threshold extremes, with offset wrap.
  task automatic test_extreme_calibration();
    axes_t smp;
    bit up;
    set_threshold(16'hFFFF);
    send_item(1'b1, '0);
    send_item(1'b0, pack_axes(-32768, -32768, -32768, 32767, -32768, 0));
    for (int n = 0; n < STILL_RUN_LEN; n++) begin
      up = (n % 2 == 0);
      send_item(1'b0, pack_axes(up ? 32767 : -32768, up ? -32768 : 32767, -32768,
                                32767, -32768, up ? 32767 : -32768));
    end
    send_item(1'b0, {AXES{16'h7FFF}});
    send_item(1'b0, {AXES{16'h8000}});
    repeat (3) send_item(1'b0, random_axes());

    // Restart from the calibrated phase, then the largest step at one below max.
    send_item(1'b1, random_axes());
    send_item(1'b0, pack_axes(32767, 32767, 32767, 0, 0, 0));
    set_threshold(16'hFFFE);
    send_item(1'b0, pack_axes(-32768, -32768, -32768, 0, 0, 0));
    send_item(1'b0, pack_axes(-32768, -32768, -32768, 0, 0, 0));

    // A zero threshold only counts identical readings as still.
    set_threshold(16'h0000);
    send_item(1'b1, random_axes());
    smp = random_axes();
    send_item(1'b0, smp);
    repeat (30) begin
      for (int i = ACC_AXES; i < AXES; i++) smp[i] = 16'($urandom);
      send_item(1'b0, smp);
    end
    smp[1] = smp[1] + 16'd1;
    send_item(1'b0, smp);
    while (cal_phase == PH_ACCUM) begin
      for (int i = ACC_AXES; i < AXES; i++) smp[i] = 16'($urandom);
      send_item(1'b0, smp);
    end
    repeat (5) send_item(1'b0, random_axes());
  endtask

  // The receiver holds off while the sender keeps offering.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_request = 300;
    repeat (40) send_item(1'b0, random_axes());
    drain_results();
    gaps_on = 1'b1;
  endtask

  // Restart, baseline, mostly still readings with rare jumps, then
  // corrected samples; some sessions are cut short.
  task automatic run_calibration_session();
    axes_t smp;
    int budget;
    int axis;
    send_item(1'b1, random_axes());
    send_item(1'b0, random_axes());
    budget = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : 400;
    while (cal_phase == PH_ACCUM && budget > 0) begin
      smp = random_axes();
      for (int i = 0; i < ACC_AXES; i++) smp[i] = near_value(prev_acc[i]);
      if ($urandom_range(0, 99) == 0) begin
        axis = $urandom_range(0, ACC_AXES - 1);
        smp[axis] = far_value(prev_acc[axis]);
      end
      send_item(1'b0, smp);
      budget--;
    end
    repeat ($urandom_range(3, 30)) send_item(1'b0, random_axes());
  endtask

  task automatic test_random_sessions();
    int first_item;
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 6))
          0: set_threshold(16'h0000);
          1: set_threshold(16'hFFFF);
          2: set_threshold(16'($urandom_range(1, 15)));
          3: set_threshold(16'($urandom));
          default: set_threshold(16'($urandom_range(100, 1000)));
        endcase
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 6) == 0) begin
        // Unstructured samples, with a restart now and then.
        repeat ($urandom_range(10, 40))
          send_item(($urandom_range(0, 19) == 0), random_axes());
      end else begin
        run_calibration_session();
      end
    end
  endtask

  initial begin
    motion_limit = THRESHOLD_RESET;
    cal_phase = PH_BASE;
    still_count = 0;
    for (int i = 0; i < ACC_AXES; i++) prev_acc[i] = 0;
    for (int i = 0; i < AXES; i++) begin
      axis_sum[i] = 0;
      axis_offset[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_extreme_calibration();
    test_backpressure();
    test_random_sessions();
    drain_results();

    $display("Sent %0d items and checked %0d results over %0d threshold writes.",
             items_sent, results_checked, threshold_writes);
    $display("Completed %0d calibrations; %0d mismatches seen.", offset_sets, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/imu_szoc_pkg.sv
rtl/imu_szoc_track.sv
rtl/imu_szoc_output.sv
rtl/imu_still_zero_offset_calibrator.sv
bench/imu_still_zero_offset_calibrator_tb.sv
